### hw/rtl/hcic_pkg.sv
// Shared types and constants for the handheld CPU instruction core.
// No dependencies; used by the front end, queue, back end and top level.
package hcic_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  fault_opcode;
    logic        fault_prefixed;
    logic [15:0] prog_counter;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STEP_IDLE   = 3'd0,
    STEP_OPCODE = 3'd1,
    STEP_CB     = 3'd2,
    STEP_IMM1   = 3'd3,
    STEP_IMM2   = 3'd4,
    STEP_MEM    = 3'd5,
    STEP_POPLO  = 3'd6,
    STEP_POPHI  = 3'd7
  } step_t;

  // Work packet from the execute unit to the result sequencer.
  typedef struct packed {
    logic [1:0]  count;
    out_item_t   r0;
    out_item_t   r1;
    out_item_t   r2;
  } pack_t;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] IoBase     = 16'hFF00;
  localparam logic [7:0]  OpPrefix   = 8'hCB;

endpackage

### hw/rtl/hcic_exec.sv
// Front end: accepts input beats, decodes and executes one step of the core.
// Depends on hcic_pkg; produces a packet of up to three results per beat.
module hcic_exec (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hcic_pkg::in_item_t in_item,
  output logic              pk_valid,
  input  logic              pk_ready,
  output hcic_pkg::pack_t   pk
);
  import hcic_pkg::*;

  logic [7:0]  a;
  logic [7:0]  rg [6];
  logic [3:0]  fl;
  logic [15:0] pc, sp;
  logic [7:0]  cur_op, imm_lo;
  logic        pfx, faulted;
  step_t       step;

  logic [7:0]  a_next;
  logic [7:0]  rg_next [6];
  logic [3:0]  fl_next;
  logic [15:0] pc_next, sp_next;
  logic [7:0]  cur_op_next, imm_lo_next;
  logic        pfx_next, faulted_next;
  step_t       step_next;

  out_item_t   res [3];
  logic [1:0]  n;
  logic        go;

  assign in_ready  = pk_ready;
  assign go        = in_valid && in_ready;

  function automatic logic [7:0] rget(input logic [2:0] c, input logic [7:0] av,
                                      input logic [7:0] r0, input logic [7:0] r1,
                                      input logic [7:0] r2, input logic [7:0] r3,
                                      input logic [7:0] r4, input logic [7:0] r5);
    logic [7:0] v;
    case (c)
      3'd0: v = r0;
      3'd1: v = r1;
      3'd2: v = r2;
      3'd3: v = r3;
      3'd4: v = r4;
      3'd5: v = r5;
      3'd7: v = av;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Decode and execute one beat.
  always_comb begin
    logic [7:0]  op, v, sv, r8, tv;
    logic [2:0]  dst, src;
    logic [15:0] hl, w, tmp;
    logic        take;
    logic [15:0] pushv;
    logic        do_push, do_fetch;
    logic [1:0]  k;
    a_next = a; fl_next = fl; pc_next = pc; sp_next = sp;
    cur_op_next = cur_op; imm_lo_next = imm_lo; pfx_next = pfx;
    faulted_next = faulted; step_next = step;
    for (int i = 0; i < 6; i++) rg_next[i] = rg[i];
    for (int i = 0; i < 3; i++) res[i] = '0;
    k = 2'd0; do_push = 1'b0; do_fetch = 1'b0; pushv = 16'd0;
    v = in_item.read_data;
    op = v; dst = v[5:3]; src = v[2:0];
    hl = {rg[4], rg[5]};
    w = {v, imm_lo};
    sv = 8'd0; r8 = 8'd0; tv = 8'd0; tmp = 16'd0; take = 1'b0;
    if (faulted) begin
      res[0].access_kind = KIND_FAULT; res[0].fault_opcode = cur_op;
      res[0].fault_prefixed = pfx; k = 2'd1;
    end else if (!in_item.req_type) begin
      do_fetch = 1'b1;
    end else begin
      case (step)
        STEP_OPCODE: begin
          cur_op_next = op; pfx_next = 1'b0; pc_next = pc + 16'd1;
          sv = rget(src, a, rg[0], rg[1], rg[2], rg[3], rg[4], rg[5]);
          tv = rget(dst, a, rg[0], rg[1], rg[2], rg[3], rg[4], rg[5]);
          do_fetch = 1'b1;
          if (op[7:6] == 2'b01 && op != 8'h76) begin
            if (src == 3'd6) begin
              res[0].bus_address = hl; k = 2'd1; step_next = STEP_MEM; do_fetch = 1'b0;
            end else if (dst == 3'd6) begin
              res[0].access_kind = KIND_WRITE; res[0].bus_address = hl;
              res[0].write_data = sv; k = 2'd1;
            end else if (dst == 3'd7) a_next = sv;
            else rg_next[dst] = sv;
          end else if (op[7:3] == 5'b10111) begin
            if (src == 3'd6) begin
              res[0].bus_address = hl; k = 2'd1; step_next = STEP_MEM; do_fetch = 1'b0;
            end else
              fl_next = {a == sv, 1'b1, a[3:0] < sv[3:0], sv > a};
          end else if ((op & 8'hC7) == 8'h04 && dst != 3'd6) begin
            r8 = tv + 8'd1;
            fl_next = {r8 == 8'd0, 1'b0, tv[3:0] == 4'hF, fl[0]};
            if (dst == 3'd7) a_next = r8; else rg_next[dst] = r8;
          end else if ((op & 8'hC7) == 8'h05 && dst != 3'd6) begin
            r8 = tv - 8'd1;
            fl_next = {r8 == 8'd0, 1'b1, tv[3:0] == 4'h0, fl[0]};
            if (dst == 3'd7) a_next = r8; else rg_next[dst] = r8;
          end else if ((op & 8'hC7) == 8'h06 && dst != 3'd6) begin
            res[0].bus_address = pc_next; k = 2'd1; step_next = STEP_IMM1; do_fetch = 1'b0;
          end else begin
            case (op)
              8'h00: ;
              8'h03: {rg_next[0], rg_next[1]} = {rg[0], rg[1]} + 16'd1;
              8'h13: {rg_next[2], rg_next[3]} = {rg[2], rg[3]} + 16'd1;
              8'h23: {rg_next[4], rg_next[5]} = hl + 16'd1;
              8'h33: sp_next = sp + 16'd1;
              8'h0A, 8'h1A, 8'h2A: begin
                res[0].bus_address = (op == 8'h0A) ? {rg[0], rg[1]} :
                                     (op == 8'h1A) ? {rg[2], rg[3]} : hl;
                k = 2'd1; step_next = STEP_MEM; do_fetch = 1'b0;
              end
              8'h22, 8'h32: begin
                res[0].access_kind = KIND_WRITE; res[0].bus_address = hl;
                res[0].write_data = a; k = 2'd1;
                {rg_next[4], rg_next[5]} = (op == 8'h22) ? hl + 16'd1 : hl - 16'd1;
              end
              8'hE2: begin
                res[0].access_kind = KIND_WRITE; res[0].bus_address = IoBase + {8'd0, rg[1]};
                res[0].write_data = a; k = 2'd1;
              end
              8'hAF: begin a_next = 8'd0; fl_next = 4'b1000; end
              8'h17: begin
                a_next = {a[6:0], fl[0]}; fl_next = {3'b000, a[7]};
              end
              OpPrefix: begin
                res[0].bus_address = pc_next; k = 2'd1; step_next = STEP_CB; do_fetch = 1'b0;
              end
              8'hE0, 8'hF0, 8'hFE, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38, 8'h01, 8'h11,
              8'h21, 8'h31, 8'hEA, 8'hFA, 8'hCD: begin
                res[0].bus_address = pc_next; k = 2'd1; step_next = STEP_IMM1; do_fetch = 1'b0;
              end
              8'hC9, 8'hC1, 8'hD1, 8'hE1: begin
                res[0].bus_address = sp; k = 2'd1; step_next = STEP_POPLO; do_fetch = 1'b0;
              end
              8'hC5: begin do_push = 1'b1; pushv = {rg[0], rg[1]}; end
              8'hD5: begin do_push = 1'b1; pushv = {rg[2], rg[3]}; end
              8'hE5: begin do_push = 1'b1; pushv = hl; end
              8'hF5: begin do_push = 1'b1; pushv = {a, fl, 4'h0}; end
              default: begin
                faulted_next = 1'b1; do_fetch = 1'b0;
                res[0].access_kind = KIND_FAULT; res[0].fault_opcode = op; k = 2'd1;
              end
            endcase
          end
        end
        STEP_CB: begin
          cur_op_next = op; pfx_next = 1'b1; pc_next = pc + 16'd1; do_fetch = 1'b1;
          if (op >= 8'h10 && op <= 8'h15) begin
            tv = rg[op[2:0]];
            rg_next[op[2:0]] = {tv[6:0], fl[0]};
            fl_next = {{tv[6:0], fl[0]} == 8'd0, 2'b00, tv[7]};
          end else if (op == 8'h7C) begin
            fl_next = {~rg[4][7], 2'b01, fl[0]};
          end else begin
            faulted_next = 1'b1; do_fetch = 1'b0;
            res[0].access_kind = KIND_FAULT; res[0].fault_opcode = op;
            res[0].fault_prefixed = 1'b1; k = 2'd1;
          end
        end
        STEP_IMM1: begin
          pc_next = pc + 16'd1; do_fetch = 1'b1;
          case (cur_op)
            8'h01, 8'h11, 8'h21, 8'h31, 8'hEA, 8'hFA, 8'hCD: begin
              imm_lo_next = v; res[0].bus_address = pc_next; k = 2'd1;
              step_next = STEP_IMM2; do_fetch = 1'b0;
            end
            8'hE0: begin
              res[0].access_kind = KIND_WRITE; res[0].bus_address = IoBase + {8'd0, v};
              res[0].write_data = a; k = 2'd1;
            end
            8'hF0: begin
              res[0].bus_address = IoBase + {8'd0, v}; k = 2'd1;
              step_next = STEP_MEM; do_fetch = 1'b0;
            end
            8'hFE: fl_next = {a == v, 1'b1, a[3:0] < v[3:0], v > a};
            8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
              take = (cur_op == 8'h18) || (cur_op == 8'h20 && !fl[3]) ||
                     (cur_op == 8'h28 && fl[3]) || (cur_op == 8'h30 && !fl[0]) ||
                     (cur_op == 8'h38 && fl[0]);
              if (take) pc_next = pc + 16'd1 + {{8{v[7]}}, v};
            end
            default: begin
              if (cur_op[5:3] == 3'd7) a_next = v;
              else if (cur_op[5:3] != 3'd6) rg_next[cur_op[5:3]] = v;
            end
          endcase
        end
        STEP_IMM2: begin
          pc_next = pc + 16'd1; do_fetch = 1'b1;
          case (cur_op)
            8'h01: {rg_next[0], rg_next[1]} = w;
            8'h11: {rg_next[2], rg_next[3]} = w;
            8'h21: {rg_next[4], rg_next[5]} = w;
            8'h31: sp_next = w;
            8'hEA: begin
              res[0].access_kind = KIND_WRITE; res[0].bus_address = w;
              res[0].write_data = a; k = 2'd1;
            end
            8'hFA: begin
              res[0].bus_address = w; k = 2'd1; step_next = STEP_MEM; do_fetch = 1'b0;
            end
            default: begin do_push = 1'b1; pushv = pc + 16'd1; end
          endcase
        end
        STEP_MEM: begin
          do_fetch = 1'b1;
          if (cur_op[7:6] == 2'b01) begin
            if (cur_op[5:3] == 3'd7) a_next = v;
            else if (cur_op[5:3] != 3'd6) rg_next[cur_op[5:3]] = v;
          end else if (cur_op[7:3] == 5'b10111)
            fl_next = {a == v, 1'b1, a[3:0] < v[3:0], v > a};
          else begin
            a_next = v;
            if (cur_op == 8'h2A) {rg_next[4], rg_next[5]} = hl + 16'd1;
          end
        end
        STEP_POPLO: begin
          imm_lo_next = v; sp_next = sp + 16'd1;
          res[0].bus_address = sp + 16'd1; k = 2'd1; step_next = STEP_POPHI;
        end
        STEP_POPHI: begin
          sp_next = sp + 16'd1; do_fetch = 1'b1;
          case (cur_op)
            8'hC1: {rg_next[0], rg_next[1]} = w;
            8'hD1: {rg_next[2], rg_next[3]} = w;
            8'hE1: {rg_next[4], rg_next[5]} = w;
            default: pc_next = w;
          endcase
        end
        default: ;
      endcase
    end
    // Push two bytes, high first, below the stack pointer.
    if (do_push) begin
      res[k].access_kind = KIND_WRITE; res[k].bus_address = sp - 16'd1;
      res[k].write_data = pushv[15:8];
      res[k + 2'd1].access_kind = KIND_WRITE; res[k + 2'd1].bus_address = sp - 16'd2;
      res[k + 2'd1].write_data = pushv[7:0];
      sp_next = sp - 16'd2;
      k = k + 2'd2;
      if (cur_op == 8'hCD && step == STEP_IMM2) pc_next = w;
    end
    // Request the next opcode.
    if (do_fetch) begin
      res[k] = '0; res[k].bus_address = pc_next; k = k + 2'd1;
      step_next = STEP_OPCODE;
    end
    tmp = pc_next;
    for (int i = 0; i < 3; i++) begin
      res[i].prog_counter = tmp;
      res[i].last = (2'(i) == k - 2'd1);
    end
    n = k;
  end

  // Commit architectural state on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0; fl <= '0; pc <= '0; sp <= '0; cur_op <= '0; imm_lo <= '0;
      pfx <= 1'b0; faulted <= 1'b0; step <= STEP_IDLE;
      for (int i = 0; i < 6; i++) rg[i] <= '0;
    end else if (go) begin
      a <= a_next; fl <= fl_next; pc <= pc_next; sp <= sp_next;
      cur_op <= cur_op_next; imm_lo <= imm_lo_next; pfx <= pfx_next;
      faulted <= faulted_next; step <= step_next;
      for (int i = 0; i < 6; i++) rg[i] <= rg_next[i];
    end
  end

  assign pk_valid   = go && (n != 2'd0);
  assign pk.count   = n;
  assign pk.r0      = res[0];
  assign pk.r1      = res[1];
  assign pk.r2      = res[2];
endmodule

### hw/rtl/hcic_queue.sv
// Short packet queue between the execute front end and the result back end.
// Depends on hcic_pkg; depth from the top-level parameter.
module hcic_queue #(
  parameter int unsigned Depth = hcic_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  hcic_pkg::pack_t wr_pk,
  output logic            rd_valid,
  input  logic            rd_ready,
  output hcic_pkg::pack_t rd_pk
);
  import hcic_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  pack_t             mem [Depth];
  logic [Aw-1:0]     wp, rp;
  logic [Aw:0]       cnt;
  logic              do_wr, do_rd;

  assign wr_ready = (cnt != (Aw+1)'(Depth)) || rd_ready;
  assign rd_valid = cnt != '0;
  assign rd_pk    = mem[rp];
  assign do_wr    = wr_valid && ((cnt != (Aw+1)'(Depth)) || do_rd);
  assign do_rd    = rd_valid && rd_ready;

  // Store a packet.
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_pk;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + Aw'(1);
      if (do_rd) rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + Aw'(1);
      cnt <= cnt + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
    end
  end
endmodule

### hw/rtl/hcic_emit.sv
// Back end: drains packets one result beat at a time onto the output channel.
// Depends on hcic_pkg.
module hcic_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                pk_valid,
  output logic                pk_ready,
  input  hcic_pkg::pack_t     pk,
  output logic                out_valid,
  input  logic                out_ready,
  output hcic_pkg::out_item_t out_item
);
  import hcic_pkg::*;

  logic [1:0] idx;

  assign out_valid = pk_valid;
  always_comb begin
    case (idx)
      2'd0:    out_item = pk.r0;
      2'd1:    out_item = pk.r1;
      default: out_item = pk.r2;
    endcase
  end
  assign pk_ready = out_valid && out_ready && (idx == pk.count - 2'd1);

  // Step through the results of the head packet.
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (out_valid && out_ready) idx <= pk_ready ? 2'd0 : idx + 2'd1;
  end
endmodule

### hw/rtl/handheld_cpu_instruction_core_unit.sv
// Handheld CPU instruction core: one input beat per cycle when the queue has room.
// Results pass through the queue's packet registers before they reach the output port.
// The back end sends one result beat per cycle while out_ready is high; a packet with n results goes out as n beats.
// Queue of QueueDepth packets decouples decode/execute from the output port.
// Reset (rst, synchronous): registers, flags, PC and SP cleared; core waits for a start beat.
module handheld_cpu_instruction_core_unit #(
  parameter int unsigned QDepth = hcic_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcic_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hcic_pkg::out_item_t out_item
);
  import hcic_pkg::*;

  pack_t wpk, rpk;
  logic  wv, wr, rv, rr;

  hcic_exec u_exec (.clk, .rst, .in_valid, .in_ready, .in_item,
                    .pk_valid(wv), .pk_ready(wr), .pk(wpk));
  hcic_queue #(.Depth(QDepth)) u_q (.clk, .rst, .wr_valid(wv), .wr_ready(wr), .wr_pk(wpk),
                    .rd_valid(rv), .rd_ready(rr), .rd_pk(rpk));
  hcic_emit u_emit (.clk, .rst, .pk_valid(rv), .pk_ready(rr), .pk(rpk),
                    .out_valid, .out_ready, .out_item);

`ifndef SYNTHESIS
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.access_kind <= KIND_FAULT) else $error("bad access kind");
  a_fault_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.access_kind == KIND_FAULT |-> out_item.bus_address == 16'd0)
    else $error("fault with address");
  a_fault_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.access_kind == KIND_FAULT |-> out_item.last)
    else $error("fault not last");
`endif
endmodule

### verif/handheld_cpu_instruction_core_unit_tb.sv
// Testbench for the handheld CPU instruction core: instruction streams in, bus requests out.
// Depends on hcic_pkg and the handheld_cpu_instruction_core_unit RTL; self-contained otherwise.
module handheld_cpu_instruction_core_unit_tb;
  import hcic_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  // Flag bit positions in the flag nibble
  localparam int FlagZ = 3;
  localparam int FlagC = 0;

  // Opcodes used by name in the directed tests
  localparam logic [7:0] OpNop    = 8'h00;
  localparam logic [7:0] OpLdBn   = 8'h06;
  localparam logic [7:0] OpIncB   = 8'h04;
  localparam logic [7:0] OpDecB   = 8'h05;
  localparam logic [7:0] OpLdCn   = 8'h0E;
  localparam logic [7:0] OpLdAn   = 8'h3E;
  localparam logic [7:0] OpLdBCnn = 8'h01;
  localparam logic [7:0] OpLdDEnn = 8'h11;
  localparam logic [7:0] OpLdHLnn = 8'h21;
  localparam logic [7:0] OpLdSPnn = 8'h31;
  localparam logic [7:0] OpIncBC  = 8'h03;
  localparam logic [7:0] OpIncDE  = 8'h13;
  localparam logic [7:0] OpIncHL  = 8'h23;
  localparam logic [7:0] OpIncSP  = 8'h33;
  localparam logic [7:0] OpLdABC  = 8'h0A;
  localparam logic [7:0] OpLdADE  = 8'h1A;
  localparam logic [7:0] OpLdiAHL = 8'h2A;
  localparam logic [7:0] OpLdiHLA = 8'h22;
  localparam logic [7:0] OpLddHLA = 8'h32;
  localparam logic [7:0] OpLdCA   = 8'hE2;
  localparam logic [7:0] OpXorA   = 8'hAF;
  localparam logic [7:0] OpRla    = 8'h17;
  localparam logic [7:0] OpLdhnA  = 8'hE0;
  localparam logic [7:0] OpLdhAn  = 8'hF0;
  localparam logic [7:0] OpCpn    = 8'hFE;
  localparam logic [7:0] OpCpHL   = 8'hBE;
  localparam logic [7:0] OpCpB    = 8'hB8;
  localparam logic [7:0] OpJr     = 8'h18;
  localparam logic [7:0] OpJrNz   = 8'h20;
  localparam logic [7:0] OpJrZ    = 8'h28;
  localparam logic [7:0] OpJrNc   = 8'h30;
  localparam logic [7:0] OpJrC    = 8'h38;
  localparam logic [7:0] OpLdnnA  = 8'hEA;
  localparam logic [7:0] OpLdAnn  = 8'hFA;
  localparam logic [7:0] OpCall   = 8'hCD;
  localparam logic [7:0] OpRet    = 8'hC9;
  localparam logic [7:0] OpPopBC  = 8'hC1;
  localparam logic [7:0] OpPopDE  = 8'hD1;
  localparam logic [7:0] OpPopHL  = 8'hE1;
  localparam logic [7:0] OpPushBC = 8'hC5;
  localparam logic [7:0] OpPushDE = 8'hD5;
  localparam logic [7:0] OpPushHL = 8'hE5;
  localparam logic [7:0] OpPushAF = 8'hF5;
  localparam logic [7:0] OpLdHLB  = 8'h70;
  localparam logic [7:0] OpLdBHL  = 8'h46;
  localparam logic [7:0] OpLdDB   = 8'h50;
  localparam logic [7:0] OpHalt   = 8'h76;
  localparam logic [7:0] OpBadIn  = 8'hD3;
  localparam logic [7:0] CbRlB    = 8'h10;
  localparam logic [7:0] CbRlL    = 8'h15;
  localparam logic [7:0] CbBit7H  = 8'h7C;
  localparam logic [7:0] CbBadSla = 8'h20;

  // Core state mirror
  logic [7:0]  a_reg;
  logic [7:0]  gpr [6];
  logic [3:0]  flags;
  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  cur_op;
  logic        cur_pfx;
  step_t       step;
  logic [7:0]  imm_lo;
  logic        halted;

  out_item_t batch[$];
  out_item_t bus_expect[$];
  int n_beats = 0;
  int n_results = 0;
  int n_errors = 0;
  logic calm = 1'b0;

  handheld_cpu_instruction_core_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 10);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (bus_expect.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat %h", $time, out_item);
      end else begin
        want = bus_expect.pop_front();
        if (out_item !== want) begin
          n_errors++;
          $display("%0t: mismatch expected kind=%0d addr=%h wd=%h fop=%h fpx=%b pc=%h last=%b",
                   $time, want.access_kind, want.bus_address, want.write_data,
                   want.fault_opcode, want.fault_prefixed, want.prog_counter, want.last);
          $display("%0t:          actual   kind=%0d addr=%h wd=%h fop=%h fpx=%b pc=%h last=%b",
                   $time, out_item.access_kind, out_item.bus_address, out_item.write_data,
                   out_item.fault_opcode, out_item.fault_prefixed, out_item.prog_counter,
                   out_item.last);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("[handheld_cpu_instruction_core_unit] ERROR");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [7:0] reg_rd(logic [2:0] c);
    if (c == 3'd7) return a_reg;
    if (c < 3'd6) return gpr[c];
    return 8'h00;
  endfunction

  function automatic void reg_wr(logic [2:0] c, logic [7:0] v);
    if (c == 3'd7) a_reg = v;
    else if (c < 3'd6) gpr[c] = v;
  endfunction

  function automatic logic [15:0] pair_rd(int i);
    return {gpr[i], gpr[i+1]};
  endfunction

  function automatic void pair_wr(int i, logic [15:0] v);
    gpr[i] = v[15:8];
    gpr[i+1] = v[7:0];
  endfunction

  function automatic void emit(kind_t k, logic [15:0] addr, logic [7:0] d);
    out_item_t r;
    r = '0;
    if (batch.size() >= 3) return;
    r.access_kind = k;
    r.bus_address = addr;
    r.write_data = (k == KIND_WRITE) ? d : 8'h00;
    r.fault_opcode = (k == KIND_FAULT) ? cur_op : 8'h00;
    r.fault_prefixed = (k == KIND_FAULT) ? cur_pfx : 1'b0;
    batch.push_back(r);
  endfunction

  function automatic void cp_flags(logic [7:0] v);
    flags = {a_reg == v, 1'b1, a_reg[3:0] < v[3:0], v > a_reg};
  endfunction

  function automatic logic [7:0] rotate_left(logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], flags[FlagC]};
    flags = {r == 8'h00, 1'b0, 1'b0, v[7]};
    return r;
  endfunction

  function automatic void push_word(logic [15:0] v);
    sp = sp - 16'd1;
    emit(KIND_WRITE, sp, v[15:8]);
    sp = sp - 16'd1;
    emit(KIND_WRITE, sp, v[7:0]);
  endfunction

  function automatic void read_operand(logic [15:0] addr);
    emit(KIND_READ, addr, 8'h00);
    step = STEP_MEM;
  endfunction

  function automatic void wait_operand(step_t nxt, logic [15:0] addr);
    emit(KIND_READ, addr, 8'h00);
    step = nxt;
  endfunction

  // Returns 1 when the instruction finished and the next opcode fetch follows
  function automatic logic run_opcode(logic [7:0] op);
    logic [2:0] dst;
    logic [2:0] src;
    logic [15:0] hl;
    logic [7:0] r;
    logic [7:0] t;
    dst = op[5:3];
    src = op[2:0];
    hl = pair_rd(4);
    cur_op = op;
    cur_pfx = 1'b0;
    pc = pc + 16'd1;
    if (op[7:6] == 2'b01 && op != OpHalt) begin
      if (src == 3'd6) begin read_operand(hl); return 0; end
      if (dst == 3'd6) emit(KIND_WRITE, hl, reg_rd(src));
      else reg_wr(dst, reg_rd(src));
    end else if (op[7:3] == 5'b10111) begin
      if (src == 3'd6) begin read_operand(hl); return 0; end
      cp_flags(reg_rd(src));
    end else if ((op & 8'hC7) == 8'h04 && dst != 3'd6) begin
      t = reg_rd(dst);
      r = t + 8'd1;
      flags[3:1] = {r == 8'h00, 1'b0, t[3:0] == 4'hF};
      reg_wr(dst, r);
    end else if ((op & 8'hC7) == 8'h05 && dst != 3'd6) begin
      t = reg_rd(dst);
      r = t - 8'd1;
      flags[3:1] = {r == 8'h00, 1'b1, t[3:0] == 4'h0};
      reg_wr(dst, r);
    end else if ((op & 8'hC7) == 8'h06 && dst != 3'd6) begin
      wait_operand(STEP_IMM1, pc);
      return 0;
    end else begin
      case (op)
        OpNop: ;
        OpIncBC: pair_wr(0, pair_rd(0) + 16'd1);
        OpIncDE: pair_wr(2, pair_rd(2) + 16'd1);
        OpIncHL: pair_wr(4, hl + 16'd1);
        OpIncSP: sp = sp + 16'd1;
        OpLdABC: begin read_operand(pair_rd(0)); return 0; end
        OpLdADE: begin read_operand(pair_rd(2)); return 0; end
        OpLdiAHL: begin read_operand(hl); return 0; end
        OpLdiHLA: begin emit(KIND_WRITE, hl, a_reg); pair_wr(4, hl + 16'd1); end
        OpLddHLA: begin emit(KIND_WRITE, hl, a_reg); pair_wr(4, hl - 16'd1); end
        OpLdCA: emit(KIND_WRITE, IoBase + {8'h00, gpr[1]}, a_reg);
        OpXorA: begin a_reg = 8'h00; flags = 4'b1000; end
        OpRla: begin a_reg = rotate_left(a_reg); flags[FlagZ] = 1'b0; end
        OpPrefix: begin wait_operand(STEP_CB, pc); return 0; end
        OpLdhnA, OpLdhAn, OpCpn, OpJr, OpJrNz, OpJrZ, OpJrNc, OpJrC,
        OpLdBCnn, OpLdDEnn, OpLdHLnn, OpLdSPnn, OpLdnnA, OpLdAnn, OpCall: begin
          wait_operand(STEP_IMM1, pc);
          return 0;
        end
        OpRet, OpPopBC, OpPopDE, OpPopHL: begin
          wait_operand(STEP_POPLO, sp);
          return 0;
        end
        OpPushBC: push_word(pair_rd(0));
        OpPushDE: push_word(pair_rd(2));
        OpPushHL: push_word(hl);
        OpPushAF: push_word({a_reg, flags, 4'h0});
        default: begin halted = 1'b1; emit(KIND_FAULT, 16'h0000, 8'h00); return 0; end
      endcase
    end
    return 1;
  endfunction

  function automatic logic run_prefixed(logic [7:0] op);
    cur_op = op;
    cur_pfx = 1'b1;
    pc = pc + 16'd1;
    if (op >= CbRlB && op <= CbRlL) begin
      gpr[op - CbRlB] = rotate_left(gpr[op - CbRlB]);
    end else if (op == CbBit7H) begin
      flags[3:1] = {~gpr[4][7], 1'b0, 1'b1};
    end else begin
      halted = 1'b1;
      emit(KIND_FAULT, 16'h0000, 8'h00);
      return 0;
    end
    return 1;
  endfunction

  function automatic logic run_imm1(logic [7:0] v);
    logic taken;
    pc = pc + 16'd1;
    case (cur_op)
      OpLdBCnn, OpLdDEnn, OpLdHLnn, OpLdSPnn, OpLdnnA, OpLdAnn, OpCall: begin
        imm_lo = v;
        wait_operand(STEP_IMM2, pc);
        return 0;
      end
      OpLdhnA: emit(KIND_WRITE, IoBase + {8'h00, v}, a_reg);
      OpLdhAn: begin read_operand(IoBase + {8'h00, v}); return 0; end
      OpCpn: cp_flags(v);
      OpJr, OpJrNz, OpJrZ, OpJrNc, OpJrC: begin
        taken = (cur_op == OpJr) || (cur_op == OpJrNz && !flags[FlagZ]) ||
                (cur_op == OpJrZ && flags[FlagZ]) || (cur_op == OpJrNc && !flags[FlagC]) ||
                (cur_op == OpJrC && flags[FlagC]);
        if (taken) pc = pc + {{8{v[7]}}, v};
      end
      default: reg_wr(cur_op[5:3], v);
    endcase
    return 1;
  endfunction

  function automatic logic run_imm2(logic [7:0] v);
    logic [15:0] w;
    w = {v, imm_lo};
    pc = pc + 16'd1;
    case (cur_op)
      OpLdBCnn: pair_wr(0, w);
      OpLdDEnn: pair_wr(2, w);
      OpLdHLnn: pair_wr(4, w);
      OpLdSPnn: sp = w;
      OpLdnnA: emit(KIND_WRITE, w, a_reg);
      OpLdAnn: begin read_operand(w); return 0; end
      default: begin push_word(pc); pc = w; end
    endcase
    return 1;
  endfunction

  function automatic void run_operand(logic [7:0] v);
    if (cur_op[7:6] == 2'b01) reg_wr(cur_op[5:3], v);
    else if (cur_op[7:3] == 5'b10111) cp_flags(v);
    else begin
      a_reg = v;
      if (cur_op == OpLdiAHL) pair_wr(4, pair_rd(4) + 16'd1);
    end
  endfunction

  function automatic void run_pop_high(logic [7:0] v);
    logic [15:0] w;
    w = {v, imm_lo};
    sp = sp + 16'd1;
    case (cur_op)
      OpPopBC: pair_wr(0, w);
      OpPopDE: pair_wr(2, w);
      OpPopHL: pair_wr(4, w);
      default: pc = w;
    endcase
  endfunction

  // Advance the mirror by one accepted beat and queue its bus results
  function automatic void predict_bus(logic rq, logic [7:0] v);
    logic fetch;
    fetch = 1'b0;
    batch.delete();
    if (halted) emit(KIND_FAULT, 16'h0000, 8'h00);
    else if (!rq) fetch = 1'b1;
    else begin
      case (step)
        STEP_OPCODE: fetch = run_opcode(v);
        STEP_CB:     fetch = run_prefixed(v);
        STEP_IMM1:   fetch = run_imm1(v);
        STEP_IMM2:   fetch = run_imm2(v);
        STEP_MEM:    begin run_operand(v); fetch = 1'b1; end
        STEP_POPLO: begin
          imm_lo = v;
          sp = sp + 16'd1;
          wait_operand(STEP_POPHI, sp);
        end
        STEP_POPHI:  begin run_pop_high(v); fetch = 1'b1; end
        default: ;
      endcase
    end
    if (fetch) begin
      emit(KIND_READ, pc, 8'h00);
      step = STEP_OPCODE;
    end
    foreach (batch[k]) begin
      batch[k].prog_counter = pc;
      batch[k].last = (k == batch.size() - 1);
      bus_expect.push_back(batch[k]);
    end
  endfunction

  function automatic logic implemented(logic [7:0] op);
    if (op[7:6] == 2'b01) return op != OpHalt;
    if (op[7:3] == 5'b10111) return 1;
    if (((op & 8'hC7) == 8'h04 || (op & 8'hC7) == 8'h05 || (op & 8'hC7) == 8'h06) &&
        op[5:3] != 3'd6) return 1;
    case (op)
      OpNop, OpIncBC, OpIncDE, OpIncHL, OpIncSP, OpLdABC, OpLdADE, OpLdiAHL, OpLdiHLA,
      OpLddHLA, OpLdCA, OpXorA, OpRla, OpPrefix, OpLdhnA, OpLdhAn, OpCpn, OpJr, OpJrNz,
      OpJrZ, OpJrNc, OpJrC, OpLdBCnn, OpLdDEnn, OpLdHLnn, OpLdSPnn, OpLdnnA, OpLdAnn,
      OpCall, OpRet, OpPopBC, OpPopDE, OpPopHL, OpPushBC, OpPushDE, OpPushHL,
      OpPushAF: return 1;
      default: return 0;
    endcase
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_beat(logic rq, logic [7:0] d);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{req_type: rq, read_data: d};
    do @(posedge clk); while (!in_ready);
    n_beats++;
    predict_bus(rq, d);
  endtask

  // Send one instruction: opcode, then operand bytes until the next fetch
  task automatic issue(logic [7:0] op, logic [7:0] b0, logic [7:0] b1);
    int idx;
    idx = 0;
    send_beat(1'b1, op);
    while (!halted && step != STEP_OPCODE) begin
      if (step == STEP_CB) send_beat(1'b1, b0);
      else send_beat(1'b1, idx == 0 ? b0 : (idx == 1 ? b1 : 8'($urandom)));
      idx++;
    end
  endtask

  task automatic drain_results();
    while (bus_expect.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_reads();
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, 8'h00);
  endtask

  task automatic test_loads_and_alu();
    issue(OpLdBn, 8'hFF, 8'h00);
    issue(OpIncB, 8'h00, 8'h00);
    issue(OpDecB, 8'h00, 8'h00);
    issue(OpLdCn, 8'h80, 8'h00);
    issue(OpLdAn, 8'h0F, 8'h00);
    issue(OpCpB, 8'h00, 8'h00);
    issue(OpCpn, 8'h10, 8'h00);
    issue(OpRla, 8'h00, 8'h00);
    issue(OpPrefix, CbRlB, 8'h00);
    issue(OpLdHLnn, 8'hFF, 8'hFF);
    issue(OpPrefix, CbBit7H, 8'h00);
    issue(OpIncHL, 8'h00, 8'h00);
    issue(OpXorA, 8'h00, 8'h00);
    issue(OpLdDB, 8'h00, 8'h00);
    issue(OpNop, 8'h00, 8'h00);
  endtask

  task automatic test_memory();
    issue(OpLdBCnn, 8'h34, 8'h12);
    issue(OpLdDEnn, 8'hFF, 8'hFF);
    issue(OpIncBC, 8'h00, 8'h00);
    issue(OpIncDE, 8'h00, 8'h00);
    issue(OpLdABC, 8'hA5, 8'h00);
    issue(OpLdADE, 8'h5A, 8'h00);
    issue(OpLdiAHL, 8'h80, 8'h00);
    issue(OpLdiHLA, 8'h00, 8'h00);
    issue(OpLddHLA, 8'h00, 8'h00);
    issue(OpLdCA, 8'h00, 8'h00);
    issue(OpLdhnA, 8'hFF, 8'h00);
    issue(OpLdhAn, 8'h00, 8'h00);
    issue(OpLdnnA, 8'h00, 8'h80);
    issue(OpLdAnn, 8'hFF, 8'hFF);
    issue(OpLdHLB, 8'h00, 8'h00);
    issue(OpLdBHL, 8'h7F, 8'h00);
    issue(OpCpHL, 8'h01, 8'h00);
  endtask

  task automatic test_stack_and_branches();
    issue(OpLdSPnn, 8'h01, 8'h00);
    issue(OpPushAF, 8'h00, 8'h00);
    issue(OpPushBC, 8'h00, 8'h00);
    issue(OpPopDE, 8'hEF, 8'hBE);
    issue(OpIncSP, 8'h00, 8'h00);
    issue(OpCall, 8'hFE, 8'hFF);
    issue(OpRet, 8'h00, 8'h10);
    issue(OpJr, 8'h80, 8'h00);
    issue(OpJrNz, 8'h7F, 8'h00);
    issue(OpJrZ, 8'h02, 8'h00);
    issue(OpJrNc, 8'hFE, 8'h00);
    issue(OpJrC, 8'h05, 8'h00);
  endtask

  // Restart in the middle of an instruction, hold until the port drains, then run push and pop instructions
  task automatic test_restart();
    send_beat(1'b1, OpLdHLnn);
    send_beat(1'b1, 8'h42);
    send_beat(1'b0, 8'h99);
    send_beat(1'b1, OpPrefix);
    send_beat(1'b0, 8'h00);
    in_valid <= 1'b0;
    @(posedge clk);
    drain_results();
    issue(OpPushHL, 8'h00, 8'h00);
    issue(OpPushDE, 8'h00, 8'h00);
    issue(OpPopHL, 8'h00, 8'hC0);
    issue(OpPopBC, 8'h11, 8'h22);
  endtask

  task automatic test_random_program(int count);
    logic [7:0] op;
    logic [7:0] cb;
    int stop_at;
    stop_at = n_beats + count;
    while (n_beats < stop_at) begin
      if ($urandom_range(99) < 8) begin
        send_beat(1'b0, 8'($urandom));
      end else if ($urandom_range(99) < 4) begin
        send_beat(1'b1, OpLdBCnn);
        send_beat(1'b0, 8'($urandom));
      end else begin
        do op = 8'($urandom); while (!implemented(op));
        case ($urandom_range(6))
          0: cb = CbBit7H;
          default: cb = CbRlB + 8'($urandom_range(5));
        endcase
        issue(op, op == OpPrefix ? cb : 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // End on an unimplemented opcode; the core then repeats its fault
  task automatic test_fault();
    if ($urandom_range(1)) send_beat(1'b1, OpBadIn);
    else begin
      send_beat(1'b1, OpPrefix);
      send_beat(1'b1, CbBadSla);
    end
    send_beat(1'b0, 8'h00);
    send_beat(1'b1, 8'($urandom));
    send_beat(1'b1, OpNop);
  endtask

  initial begin
    int guard;
    a_reg = '0; flags = '0; pc = '0; sp = '0; cur_op = '0; cur_pfx = 1'b0;
    step = STEP_IDLE; imm_lo = '0; halted = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle_reads();
    test_loads_and_alu();
    test_memory();
    test_stack_and_branches();
    test_restart();
    calm = 1'b1;
    test_random_program(70);
    calm = 1'b0;
    test_random_program(200);
    test_fault();
    in_valid <= 1'b0;
    guard = 0;
    while (bus_expect.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    $display("Covered %0d input beats and %0d result beats: loads, ALU, CB ops, memory,",
             n_beats, n_results);
    $display("stack, calls, branches, restarts mid-instruction and the fault stop.");
    if (n_errors == 0 && bus_expect.size() == 0) begin
      $display("[handheld_cpu_instruction_core_unit] OK");
    end else begin
      $display("[handheld_cpu_instruction_core_unit] ERROR");
    end
    $finish;
  end

endmodule
